[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define CRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/crt_pkg.sv]
package crt_pkg;

  localparam int CRT_SLOTS       = 16;
  localparam int CRT_MAX_PARTS   = 16;
  localparam int CRT_CHUNK_WORDS = 8;

  // parts after clipping, wide enough for the largest MAX_PARTS
  localparam int PARTS_W = 7;
  localparam int SIZE_W  = 11;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd2047;
  localparam logic [3:0] BYTES_MAX = 4'd8;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  localparam logic FUNC_CHUNK = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_MISS = 2'd2
  } crt_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } crt_state_t;

  typedef struct packed {
    logic        func;
    logic [15:0] seq_no;
    logic [3:0]  ord_no;
    logic [4:0]  parts;
    logic        compressed;
    logic [2:0]  word_index;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic [6:0]  read_addr;
  } crt_in_t;

  typedef struct packed {
    crt_kind_t   kind;
    logic [15:0] out_seq_no;
    logic [10:0] total_size;
    logic        out_compressed;
    logic [63:0] read_data;
  } crt_out_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic               func;
    logic [15:0]        seq;
    logic [15:0]        quot;     // seq / SLOTS
    logic [3:0]         ord;
    logic [PARTS_W-1:0] parts;    // clipped to MAX_PARTS
    logic               comp;
    logic [2:0]         widx;
    logic [63:0]        data;
    logic [3:0]         bytes;    // clipped to 8
    logic               last;
    logic [6:0]         raddr;
    logic               ord_ok;
    logic               widx_ok;
    logic               raddr_ok;
  } crt_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } crt_qstat_t;

endpackage

[rtl/chunk_reassembly_table_unit.sv]
// Chunk reassembly table.
// Requests enter on start/in_req and are taken at a clock edge with start high
// and busy low. A chunk word updates the slot (seq_no mod SLOTS) and the packet
// buffer; a read request looks up one stored word of a packet.
// Results leave on out_res with out_valid high for exactly one cycle: a
// completion when a packet's last missing chunk ends, and a data or miss
// answer for every read. Chunk words that do not complete give nothing.
// The receiver cannot stall; every strobe is a delivered result.
// Path: the queue entry, the pop into the command register, the LOOK read
// of slot metadata and buffer, and the EXEC result register behind the strobe.
// Each request runs through LOOK and EXEC in turn, for the slot metadata
// read-modify-write (registered memory read, then write back); a queued request is popped during EXEC.
// A 2-entry request queue sits between intake and execution; busy is high
// while it is full.
// Reset clears slot valid bits, the queue and the sequencer at once; no
// clearing pass. Buffer words hold no defined value until written.
`include "assert_macros.svh"

module chunk_reassembly_table_unit import crt_pkg::*; #(
  parameter int SLOTS       = CRT_SLOTS,
  parameter int MAX_PARTS   = CRT_MAX_PARTS,
  parameter int CHUNK_WORDS = CRT_CHUNK_WORDS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  crt_in_t  in_req,
  output logic     busy,
  output logic     out_valid,
  output crt_out_t out_res
);

  crt_cmd_t   front_cmd;
  crt_cmd_t   q_head;
  crt_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;

  crt_front #(
    .SLOTS      (SLOTS),
    .MAX_PARTS  (MAX_PARTS),
    .CHUNK_WORDS(CHUNK_WORDS)
  ) u_front (
    .in_req(in_req),
    .cmd   (front_cmd)
  );

  assign busy   = q_stat.full;
  assign q_push = start && !busy;

  crt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(front_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .stat    (q_stat)
  );

  crt_back #(
    .SLOTS      (SLOTS),
    .MAX_PARTS  (MAX_PARTS),
    .CHUNK_WORDS(CHUNK_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .qstat    (q_stat),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  `CRT_ASSERT(a_no_push_full, clk, rst_n, q_push |-> !q_stat.full, "push into full queue")
  `CRT_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
  `CRT_ASSERT(a_result_spacing, clk, rst_n, out_valid |=> !out_valid, "back-to-back results")
  `CRT_ASSERT(a_miss_clean, clk, rst_n, (out_valid && out_res.kind == KIND_MISS) |-> (out_res.total_size == '0 && out_res.read_data == '0 && !out_res.out_compressed), "miss result carries data")
  `CRT_ASSERT_ALWAYS(a_done_nodata, clk, (out_valid && out_res.kind == KIND_DONE) |-> (out_res.read_data == '0), "completion with read data")

endmodule

[rtl/crt_front.sv]
module crt_front import crt_pkg::*; #(
  parameter int SLOTS       = CRT_SLOTS,
  parameter int MAX_PARTS   = CRT_MAX_PARTS,
  parameter int CHUNK_WORDS = CRT_CHUNK_WORDS
) (
  input  crt_in_t  in_req,
  output crt_cmd_t cmd
);

  localparam int PKT_WORDS = MAX_PARTS * CHUNK_WORDS;
  // ceil(2^32 / SLOTS): exact quotient for any 16-bit sequence number
  localparam longint unsigned RECIP =
    ((64'd1 << 32) + longint'(SLOTS) - 64'd1) / longint'(SLOTS);

  logic [47:0] quot_prod;

  always_comb begin
    quot_prod = 48'(in_req.seq_no) * 48'(RECIP);

    cmd.func     = in_req.func;
    cmd.seq      = in_req.seq_no;
    cmd.quot     = quot_prod[47:32];
    cmd.ord      = in_req.ord_no;
    cmd.parts    = (int'(in_req.parts) > MAX_PARTS) ? PARTS_W'(MAX_PARTS)
                                                   : PARTS_W'(in_req.parts);
    cmd.comp     = in_req.compressed;
    cmd.widx     = in_req.word_index;
    cmd.data     = in_req.data_word;
    cmd.bytes    = (in_req.byte_count > BYTES_MAX) ? BYTES_MAX : in_req.byte_count;
    cmd.last     = in_req.last_word;
    cmd.raddr    = in_req.read_addr;
    cmd.ord_ok   = int'(in_req.ord_no) < MAX_PARTS;
    cmd.widx_ok  = int'(in_req.word_index) < CHUNK_WORDS;
    cmd.raddr_ok = int'(in_req.read_addr) < PKT_WORDS;
  end

endmodule

[rtl/crt_queue.sv]
module crt_queue import crt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  crt_cmd_t   push_cmd,
  input  logic       pop,
  output crt_cmd_t   head,
  output crt_qstat_t stat
);

  crt_cmd_t          ent_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.full  = int'(cnt_r) == Q_DEPTH;
  assign stat.empty = cnt_r == '0;

endmodule

[rtl/crt_back.sv]
module crt_back import crt_pkg::*; #(
  parameter int SLOTS       = CRT_SLOTS,
  parameter int MAX_PARTS   = CRT_MAX_PARTS,
  parameter int CHUNK_WORDS = CRT_CHUNK_WORDS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  crt_cmd_t   head,
  input  crt_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  output crt_out_t   out_res
);

  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int PKT_WORDS = MAX_PARTS * CHUNK_WORDS;
  localparam int ST_DEPTH  = SLOTS * PKT_WORDS;
  localparam int ST_AW     = $clog2(ST_DEPTH);
  localparam int MASK_W    = MAX_PARTS;

  crt_state_t state_r, state_nxt;
  logic       do_look, do_exec;

  crt_cmd_t          cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [23:0]       head_qm;
  logic [15:0]       head_rem;

  // packet buffer and per-slot metadata
  logic [63:0]       st_mem    [ST_DEPTH];
  logic [15:0]       mseq_mem  [SLOTS];
  logic [MASK_W-1:0] mmask_mem [SLOTS];
  logic [SIZE_W-1:0] msize_mem [SLOTS];
  logic              mcomp_mem [SLOTS];
  logic [SLOTS-1:0]  valid_r;

  logic [ST_AW-1:0]  st_addr, st_addr_r, st_base, st_off;
  logic [63:0]       st_rd_r;
  logic [15:0]       mseq_rd_r;
  logic [MASK_W-1:0] mmask_rd_r;
  logic [SIZE_W-1:0] msize_rd_r;
  logic              mcomp_rd_r;
  logic              vld_rd_r;

  logic              hit, take, done, st_we, meta_we, res_vld;
  logic [MASK_W-1:0] claim_mask, cur_mask, new_mask, ord_bit;
  logic [SIZE_W-1:0] cur_size, new_size;
  logic [SIZE_W:0]   size_sum;
  logic              cur_comp;
  crt_out_t          res;
  logic              out_valid_r;
  crt_out_t          out_res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!qstat.empty) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = qstat.empty ? ST_IDLE : ST_LOOK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    do_look = 1'b0;
    do_exec = 1'b0;
    case (state_r)
      ST_IDLE: pop = !qstat.empty;
      ST_LOOK: do_look = 1'b1;
      ST_EXEC: begin
        do_exec = 1'b1;
        pop     = !qstat.empty;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // slot = seq mod SLOTS from the quotient computed up front
  always_comb begin
    head_qm  = 24'(head.quot) * 24'(SLOTS);
    head_rem = head.seq - head_qm[15:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r  <= head;
      slot_r <= head_rem[SLOT_W-1:0];
    end
  end

  always_comb begin
    st_base = ST_AW'(slot_r) * ST_AW'(PKT_WORDS);
    if (cmd_r.func == FUNC_READ) begin
      st_off = ST_AW'(cmd_r.raddr);
    end else begin
      st_off = ST_AW'(cmd_r.ord) * ST_AW'(CHUNK_WORDS) + ST_AW'(cmd_r.widx);
    end
    st_addr = st_base + st_off;
  end

  always_ff @(posedge clk) begin
    if (do_look) begin
      st_rd_r    <= st_mem[st_addr];
      st_addr_r  <= st_addr;
      mseq_rd_r  <= mseq_mem[slot_r];
      mmask_rd_r <= mmask_mem[slot_r];
      msize_rd_r <= msize_mem[slot_r];
      mcomp_rd_r <= mcomp_mem[slot_r];
    end
    if (st_we) begin
      st_mem[st_addr_r] <= cmd_r.data;
    end
    if (meta_we) begin
      mseq_mem[slot_r]  <= cmd_r.seq;
      mmask_mem[slot_r] <= new_mask;
      msize_mem[slot_r] <= new_size;
      mcomp_mem[slot_r] <= cur_comp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (do_look) begin
        vld_rd_r <= valid_r[slot_r];
      end
      if (meta_we) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    hit = vld_rd_r && (mseq_rd_r == cmd_r.seq);
    for (int i = 0; i < MASK_W; i++) begin
      claim_mask[i] = i < int'(cmd_r.parts);
    end
    // a new sequence claims the slot
    cur_mask = hit ? mmask_rd_r : claim_mask;
    cur_size = hit ? msize_rd_r : '0;
    cur_comp = hit ? mcomp_rd_r : cmd_r.comp;

    ord_bit  = cmd_r.ord_ok ? (MASK_W'(1) << cmd_r.ord) : '0;
    take     = (cur_mask & ord_bit) != '0;   // duplicates leave no trace
    size_sum = {1'b0, cur_size} + (SIZE_W + 1)'(cmd_r.bytes);
    new_size = cur_size;
    new_mask = cur_mask;
    if (take) begin
      new_size = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
      if (cmd_r.last) begin
        new_mask = cur_mask & ~ord_bit;
      end
    end
    done    = take && cmd_r.last && (new_mask == '0);
    meta_we = do_exec && (cmd_r.func == FUNC_CHUNK);
    st_we   = meta_we && take && cmd_r.widx_ok;

    res.kind           = KIND_DONE;
    res.out_seq_no     = cmd_r.seq;
    res.total_size     = '0;
    res.out_compressed = 1'b0;
    res.read_data      = '0;
    if (cmd_r.func == FUNC_READ) begin
      res_vld = 1'b1;
      if (hit) begin
        res.kind           = KIND_DATA;
        res.total_size     = msize_rd_r;
        res.out_compressed = mcomp_rd_r;
        res.read_data      = cmd_r.raddr_ok ? st_rd_r : '0;
      end else begin
        res.kind = KIND_MISS;
      end
    end else begin
      res_vld            = done;
      res.total_size     = new_size;
      res.out_compressed = cur_comp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= do_exec && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[test/chunk_reassembly_table_unit_test.sv]
module chunk_reassembly_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;

  localparam int PKT_WORDS    = CRT_MAX_PARTS * CRT_CHUNK_WORDS;
  localparam int STORE_WORDS  = CRT_SLOTS * PKT_WORDS;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    crt_in_t  req;
    logic     typed;
    crt_out_t want;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  crt_in_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  crt_out_t out_res;

  chunk_reassembly_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the slot table and packet buffer
  bit                       slot_live    [CRT_SLOTS];
  logic [15:0]              slot_owner   [CRT_SLOTS];
  logic [CRT_MAX_PARTS-1:0] slot_missing [CRT_SLOTS];
  logic [SIZE_W-1:0]        slot_bytes   [CRT_SLOTS];
  logic                     slot_comp    [CRT_SLOTS];
  logic [63:0]              buf_word     [STORE_WORDS];
  bit                       buf_written  [STORE_WORDS];

  crt_out_t    due_results[$];
  crt_in_t     pending_reqs[$];
  crt_in_t     pkt_words[$];
  logic [15:0] recent_seqs[$];

  int unsigned taken_reqs = 0;
  int unsigned useful_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit          failed = 1'b0;
  logic        cur_typed = 1'b0;
  crt_out_t    cur_want = '0;
  crt_out_t    want_res;
  crt_out_t    model_res;
  bit          model_emit;

  function automatic void reassemble(input crt_in_t r, output bit emit,
                                     output crt_out_t res);
    int slot, base, np, nb, sum;
    bit hit;
    emit = 1'b0;
    res  = '0;
    slot = r.seq_no % CRT_SLOTS;
    base = slot * PKT_WORDS;
    hit  = slot_live[slot] && slot_owner[slot] == r.seq_no;
    if (r.func == FUNC_READ) begin
      useful_cnt++;
      emit = 1'b1;
      res.out_seq_no = r.seq_no;
      if (!hit) begin
        res.kind = KIND_MISS;
      end else begin
        res.kind = KIND_DATA;
        res.total_size = slot_bytes[slot];
        res.out_compressed = slot_comp[slot];
        if (r.read_addr < PKT_WORDS) res.read_data = buf_word[base + r.read_addr];
      end
      return;
    end
    if (!hit) begin
      np = (r.parts > CRT_MAX_PARTS) ? CRT_MAX_PARTS : r.parts;
      slot_live[slot]    = 1'b1;
      slot_owner[slot]   = r.seq_no;
      slot_missing[slot] = CRT_MAX_PARTS'((64'd1 << np) - 64'd1);
      slot_bytes[slot]   = '0;
      slot_comp[slot]    = r.compressed;
    end
    // chunk already done, or beyond the packet: dropped
    if (r.ord_no >= CRT_MAX_PARTS || !slot_missing[slot][r.ord_no]) return;
    useful_cnt++;
    if (r.word_index < CRT_CHUNK_WORDS) begin
      buf_word[base + r.ord_no * CRT_CHUNK_WORDS + r.word_index]    = r.data_word;
      buf_written[base + r.ord_no * CRT_CHUNK_WORDS + r.word_index] = 1'b1;
    end
    nb  = (r.byte_count > BYTES_MAX) ? BYTES_MAX : r.byte_count;
    sum = slot_bytes[slot] + nb;
    if (sum > SIZE_MAX) sum = SIZE_MAX;
    slot_bytes[slot] = SIZE_W'(sum);
    if (r.last_word) begin
      slot_missing[slot][r.ord_no] = 1'b0;
      if (slot_missing[slot] == '0) begin
        emit = 1'b1;
        res.kind = KIND_DONE;
        res.out_seq_no = r.seq_no;
        res.total_size = slot_bytes[slot];
        res.out_compressed = slot_comp[slot];
      end
    end
  endfunction

  // a read hit must land on a buffer word that holds data; else turn it into a miss
  function automatic crt_in_t aim_read(input crt_in_t r);
    int slot, ofs, pick;
    slot = r.seq_no % CRT_SLOTS;
    if (!(slot_live[slot] && slot_owner[slot] == r.seq_no)) return r;
    ofs  = $urandom_range(0, PKT_WORDS - 1);
    pick = -1;
    for (int k = 0; k < PKT_WORDS && pick < 0; k++)
      if (buf_written[slot * PKT_WORDS + (ofs + k) % PKT_WORDS]) pick = (ofs + k) % PKT_WORDS;
    if (pick < 0) r.seq_no = r.seq_no ^ 16'(CRT_SLOTS);
    else r.read_addr = 7'(pick);
    return r;
  endfunction

  function automatic crt_in_t chunk_word(logic [15:0] seq, logic [3:0] ord, logic [4:0] parts,
                                         logic comp, logic [2:0] widx, logic [63:0] data,
                                         logic [3:0] bytes, logic last);
    crt_in_t r;
    r = '0;
    r.func       = FUNC_CHUNK;
    r.seq_no     = seq;
    r.ord_no     = ord;
    r.parts      = parts;
    r.compressed = comp;
    r.word_index = widx;
    r.data_word  = data;
    r.byte_count = bytes;
    r.last_word  = last;
    return r;
  endfunction

  function automatic crt_in_t read_req(logic [15:0] seq, logic [6:0] addr);
    crt_in_t r;
    r = '0;
    r.func      = FUNC_READ;
    r.seq_no    = seq;
    r.read_addr = addr;
    return r;
  endfunction

  function automatic crt_out_t result_of(crt_kind_t kind, logic [15:0] seq, logic [10:0] size,
                                         logic comp, logic [63:0] data);
    crt_out_t o;
    o.kind           = kind;
    o.out_seq_no     = seq;
    o.total_size     = size;
    o.out_compressed = comp;
    o.read_data      = data;
    return o;
  endfunction

  function automatic plan_row_t row(crt_in_t req, logic typed, crt_out_t want);
    plan_row_t p;
    p.req   = req;
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  function automatic logic [15:0] pick_seq();
    logic [15:0] s;
    int sel;
    sel = $urandom_range(0, 99);
    if (recent_seqs.size() == 0 || sel < 55) begin
      s = 16'($urandom);
      recent_seqs.push_back(s);
      if (recent_seqs.size() > 8) void'(recent_seqs.pop_front());
    end else begin
      s = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
      // same slot, other packet
      if (sel >= 85) s = s ^ 16'(CRT_SLOTS * $urandom_range(1, 15));
    end
    return s;
  endfunction

  task automatic build_packet(input logic [15:0] seq, input bit oversize);
    logic [4:0] parts;
    logic       comp;
    int         sel, np, nw, j, t;
    int         order[$];
    pkt_words.delete();
    comp = 1'($urandom);
    sel  = $urandom_range(0, 99);
    if (oversize) parts = 5'd1;
    else if (sel < 75) parts = 5'($urandom_range(1, 5));
    else if (sel < 88) parts = 5'($urandom_range(6, 16));
    else if (sel < 94) parts = 5'd0;
    else parts = 5'($urandom_range(17, 31));
    np = (parts > CRT_MAX_PARTS) ? CRT_MAX_PARTS : parts;
    for (int i = 0; i < np; i++) order.push_back(i);
    for (int i = np - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    if (np == 0) order.push_back($urandom_range(0, 15));
    if (!oversize) begin
      // drop a chunk so the packet stays open, or add a stray/repeated chunk
      if (np > 1 && $urandom_range(0, 9) == 0) void'(order.pop_back());
      if ($urandom_range(0, 4) == 0)
        order.insert($urandom_range(0, order.size()), $urandom_range(0, 15));
    end
    foreach (order[i]) begin
      if (oversize) nw = $urandom_range(256, 300);
      else if ($urandom_range(0, 3) == 0) nw = $urandom_range(1, 8);
      else nw = $urandom_range(1, 2);
      for (int w = 0; w < nw; w++)
        pkt_words.push_back(chunk_word(seq, 4'(order[i]), parts, comp,
          ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'(w), {$urandom, $urandom},
          oversize ? 4'd8 : (($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                           : 4'($urandom_range(0, 8))),
          w == nw - 1));
      if ($urandom_range(0, 4) == 0) pkt_words.push_back(read_req(seq, '0));
    end
  endtask

  // drive one request at the falling edge, hold it until taken
  task automatic send_req(input crt_in_t req, input logic typed, input crt_out_t want);
    int unsigned mark;
    int          idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) == 0) idle = 0;
      else if ($urandom_range(0, 9) == 0) idle = $urandom_range(8, 20);
      else idle = $urandom_range(1, 4);
      if (idle > 0) begin
        start = 1'b0;
        repeat (idle) @(negedge clk);
      end
    end
    burst_left--;
    in_req    = req;
    cur_typed = typed;
    cur_want  = want;
    start     = 1'b1;
    mark      = taken_reqs;
    do @(negedge clk); while (taken_reqs == mark);
  endtask

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d seq %h",
                   $time, out_res.kind, out_res.out_seq_no);
          failed = 1'b1;
        end else begin
          want_res = due_results.pop_front();
          cmp_field("kind", want_res.kind, out_res.kind);
          cmp_field("out_seq_no", want_res.out_seq_no, out_res.out_seq_no);
          cmp_field("total_size", want_res.total_size, out_res.total_size);
          cmp_field("out_compressed", want_res.out_compressed, out_res.out_compressed);
          cmp_field("read_data", want_res.read_data, out_res.read_data);
        end
      end
      if (start && !busy) begin
        reassemble(in_req, model_emit, model_res);
        if (cur_typed) due_results.push_back(cur_want);
        else if (model_emit) due_results.push_back(model_res);
        taken_reqs++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    crt_in_t     req;
    crt_in_t     held[$];
    logic [127:0] raw;
    int          sel;
    int unsigned base;

    for (int s = 0; s < CRT_SLOTS; s++) begin
      slot_live[s]    = 1'b0;
      slot_owner[s]   = '0;
      slot_missing[s] = '1;
      slot_bytes[s]   = '0;
      slot_comp[s]    = 1'b1;
    end

    // empty table, single-chunk packet, extremes of seq and data
    plan.push_back(row(read_req(16'h0000, 7'd0), 1'b1,
                       result_of(KIND_MISS, 16'h0000, '0, 1'b0, '0)));
    plan.push_back(row(read_req(16'hFFFF, 7'd127), 1'b1,
                       result_of(KIND_MISS, 16'hFFFF, '0, 1'b0, '0)));
    plan.push_back(row(chunk_word(16'd5, 4'd0, 5'd1, 1'b1, 3'd0, '1, 4'd8, 1'b1), 1'b1,
                       result_of(KIND_DONE, 16'd5, 11'd8, 1'b1, '0)));
    plan.push_back(row(read_req(16'd5, 7'd0), 1'b1,
                       result_of(KIND_DATA, 16'd5, 11'd8, 1'b1, '1)));
    // repeated chunk is dropped
    plan.push_back(row(chunk_word(16'd5, 4'd0, 5'd1, 1'b0, 3'd3, 64'h0123_4567_89AB_CDEF,
                                  4'd8, 1'b1), 1'b0, '0));
    plan.push_back(row(read_req(16'd5, 7'd0), 1'b0, '0));
    plan.push_back(row(read_req(16'd21, 7'd0), 1'b1,
                       result_of(KIND_MISS, 16'd21, '0, 1'b0, '0)));
    // parts above max, byte count above 8, last chunk and word
    plan.push_back(row(chunk_word(16'hFFFF, 4'd15, 5'd31, 1'b0, 3'd7, '0, 4'd15, 1'b1),
                       1'b0, '0));
    plan.push_back(row(read_req(16'hFFFF, 7'd127), 1'b1,
                       result_of(KIND_DATA, 16'hFFFF, 11'd8, 1'b0, '0)));
    plan.push_back(row(chunk_word(16'hFFFF, 4'd14, 5'd0, 1'b1, 3'd7, 64'hA5A5_5A5A_F00F_0FF0,
                                  4'd9, 1'b0), 1'b0, '0));
    plan.push_back(row(read_req(16'hFFFF, 7'd119), 1'b0, '0));
    // parts zero never completes
    plan.push_back(row(chunk_word(16'd2, 4'd0, 5'd0, 1'b1, 3'd0, 64'h1, 4'd8, 1'b1), 1'b0, '0));
    plan.push_back(row(chunk_word(16'd2, 4'd3, 5'd0, 1'b1, 3'd1, 64'h2, 4'd8, 1'b1), 1'b0, '0));
    // three-part packet, out of order, with a chunk beyond parts
    plan.push_back(row(chunk_word(16'd7, 4'd4, 5'd3, 1'b0, 3'd0, 64'h3, 4'd8, 1'b1), 1'b0, '0));
    plan.push_back(row(chunk_word(16'd7, 4'd2, 5'd3, 1'b0, 3'd0, 64'h4, 4'd0, 1'b1), 1'b0, '0));
    plan.push_back(row(chunk_word(16'd7, 4'd0, 5'd3, 1'b0, 3'd0, 64'h5, 4'd5, 1'b0), 1'b0, '0));
    plan.push_back(row(chunk_word(16'd7, 4'd0, 5'd3, 1'b0, 3'd7, 64'h6, 4'd8, 1'b1), 1'b0, '0));
    plan.push_back(row(chunk_word(16'd7, 4'd1, 5'd3, 1'b0, 3'd0, 64'h7, 4'd3, 1'b1), 1'b0, '0));
    plan.push_back(row(read_req(16'd7, 7'd16), 1'b0, '0));
    // another packet takes the slot over
    plan.push_back(row(chunk_word(16'h0017, 4'd0, 5'd2, 1'b1, 3'd1, 64'h8, 4'd4, 1'b1),
                       1'b0, '0));
    plan.push_back(row(read_req(16'd7, 7'd0), 1'b1,
                       result_of(KIND_MISS, 16'd7, '0, 1'b0, '0)));
    plan.push_back(row(read_req(16'h0017, 7'd16), 1'b0, '0));
    plan.push_back(row(chunk_word(16'h0017, 4'd1, 5'd2, 1'b1, 3'd0, 64'h9, 4'd0, 1'b1),
                       1'b0, '0));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);

    // open with one packet long enough to saturate the size
    base = useful_cnt;
    build_packet(16'($urandom), 1'b1);
    pending_reqs = pkt_words;
    while (useful_cnt - base < RANDOM_ITEMS) begin
      if (pending_reqs.size() == 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          build_packet(pick_seq(), 1'b0);
          pending_reqs = pkt_words;
        end else if (sel < 75) begin
          build_packet(pick_seq(), 1'b0);
          held = pkt_words;
          build_packet(pick_seq(), 1'b0);
          while (held.size() > 0 || pkt_words.size() > 0)
            if (pkt_words.size() == 0 || (held.size() > 0 && $urandom_range(0, 1) == 1))
              pending_reqs.push_back(held.pop_front());
            else
              pending_reqs.push_back(pkt_words.pop_front());
        end else if (sel < 88) begin
          repeat ($urandom_range(1, 6))
            pending_reqs.push_back(read_req(pick_seq(), 7'($urandom)));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            req = raw[$bits(crt_in_t)-1:0];
            pending_reqs.push_back(req);
          end
        end
      end
      req = pending_reqs.pop_front();
      if (req.func == FUNC_READ) req = aim_read(req);
      send_req(req, 1'b0, '0);
    end

    start = 1'b0;
    while (due_results.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[chunk_reassembly_table_unit.f]
+incdir+rtl
rtl/crt_pkg.sv
rtl/crt_front.sv
rtl/crt_queue.sv
rtl/crt_back.sv
rtl/chunk_reassembly_table_unit.sv
test/chunk_reassembly_table_unit_test.sv
